>>> sv/pss_pkg.sv
// Package for the priority stack sweep scheduler: sizes, types and the squash table.
// Depends on nothing; every other file but pss_ram and tb_top imports it.
`timescale 1ns / 1ps
package pss_pkg;

	localparam int QUEUE_COUNT = 128;
	localparam int POOL_DEPTH  = 1024;
	localparam int TAG_BITS    = 16;

	localparam int QW  = $clog2(QUEUE_COUNT);     // queue number width
	localparam int IW  = $clog2(POOL_DEPTH);      // node index width
	localparam int PW  = IW + 1;                  // node pointer width, null included
	localparam int SW  = QW + 2;                  // signed sweep position width
	localparam int NOUT_W = 7;
	localparam int SQ_DEPTH = 1 << NOUT_W;

	localparam logic [PW-1:0] NULL_NODE = PW'(POOL_DEPTH);

	// squash term round(0.0032n^2 + 0.32n - 3.0) for every cards_out code
	typedef logic signed [7:0] sq_tbl_t [SQ_DEPTH];

	function automatic sq_tbl_t build_squash();
		sq_tbl_t t;
		int n;
		for (n = 0; n < SQ_DEPTH; n++) begin
			t[n] = 8'((32 * n * n + 3200 * n + 5000) / 10000 - 3);
		end
		return t;
	endfunction

	localparam sq_tbl_t SQUASH_TBL = build_squash();

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PUSH_CHK,
		ST_PUSH_WR,
		ST_SWEEP,
		ST_POP_HEAD,
		ST_POP_NODE,
		ST_POP_WR,
		ST_DROP
	} pss_state_t;

	typedef struct packed {
		logic load;
		logic push_chk;
		logic push_wr;
		logic sweep;
		logic pop_head;
		logic pop_node;
		logic pop_wr;
		logic drop;
	} pss_cmd_t;

	typedef struct packed {
		logic full;
		logic sw_found;
		logic sw_empty;
		logic drop_go;
	} pss_stat_t;

endpackage

>>> sv/priority_stack_sweep_scheduler_core.sv
// Top level of the priority stack sweep scheduler: controller plus datapath.
// Depends on pss_pkg, pss_ctrl, pss_dpath (and pss_ram below it).
//
// Usage: raise start with kind/tag/move_pri/cards_out while busy is low; the word is
// taken on that edge. kind 0 pushes tag onto the stack picked by move_pri plus the
// squash of cards_out; kind 1 pops the next tag from the round-robin sweep.
// Each command yields exactly one result word, shown for one cycle with done high:
// tag_out, got_item, dropped, queue_index. The receiver cannot stall; the word is
// gone after that cycle.
// Steps: a push checks the pool, then writes the node; a full pool ends at the check.
// A pop walks the sweep a step at a time, then reads the stack head, reads the node
// and frees it before done, drops the top mark past each emptied queue, and closes;
// an empty pop shows done right after its last sweep step. busy stays high until the
// drop finishes, so the next word is taken right after; walk and drop set the rate.
// Reset (arst_n low): all stacks empty, free list holds every node in order, top mark,
// sweep position and floor at zero. No clearing pass is needed.
`timescale 1ns / 1ps
module priority_stack_sweep_scheduler_core import pss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              kind,
	input  logic [15:0]       tag,
	input  logic signed [7:0] move_pri,
	input  logic [6:0]        cards_out,
	output logic              done,
	output logic [15:0]       tag_out,
	output logic              got_item,
	output logic              dropped,
	output logic [6:0]        queue_index
);

	pss_cmd_t  cmd;
	pss_stat_t stat;

	pss_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind),
		.stat(stat), .cmd(cmd), .busy(busy)
	);

	pss_dpath u_dpath (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .kind(kind), .tag(tag),
		.move_pri(move_pri), .cards_out(cards_out), .stat(stat), .done(done),
		.tag_out(tag_out), .got_item(got_item), .dropped(dropped),
		.queue_index(queue_index)
	);

endmodule

>>> sv/pss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> sv/pss_ctrl.sv
// Controller state machine of the scheduler: sequences push, sweep, pop and top drop.
// Depends on pss_pkg.
`timescale 1ns / 1ps
module pss_ctrl import pss_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	input  logic      kind,
	input  pss_stat_t stat,
	output pss_cmd_t  cmd,
	output logic      busy
);

	pss_state_t state_q, state_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (start) state_nxt = kind ? ST_SWEEP : ST_PUSH_CHK;
			end
			ST_PUSH_CHK: begin
				state_nxt = stat.full ? ST_IDLE : ST_PUSH_WR;
			end
			ST_PUSH_WR:  state_nxt = ST_IDLE;
			ST_SWEEP: begin
				if (stat.sw_empty) state_nxt = ST_IDLE;
				else if (stat.sw_found) state_nxt = ST_POP_HEAD;
			end
			ST_POP_HEAD: state_nxt = ST_POP_NODE;
			ST_POP_NODE: state_nxt = ST_POP_WR;
			ST_POP_WR:   state_nxt = ST_DROP;
			ST_DROP: begin
				if (!stat.drop_go) state_nxt = ST_IDLE;
			end
			default:     state_nxt = ST_IDLE;
		endcase
	end

	// commands
	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:     cmd.load = start;
			ST_PUSH_CHK: cmd.push_chk = 1'b1;
			ST_PUSH_WR:  cmd.push_wr = 1'b1;
			ST_SWEEP:    cmd.sweep = 1'b1;
			ST_POP_HEAD: cmd.pop_head = 1'b1;
			ST_POP_NODE: cmd.pop_node = 1'b1;
			ST_POP_WR:   cmd.pop_wr = 1'b1;
			ST_DROP:     cmd.drop = 1'b1;
			default:     cmd = '0;
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

>>> sv/pss_dpath.sv
// Datapath of the scheduler: node pool, stack heads, occupancy map, sweep and result words.
// Depends on pss_pkg and pss_ram.
`timescale 1ns / 1ps
module pss_dpath import pss_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pss_cmd_t             cmd,
	input  logic                 kind,
	input  logic [15:0]          tag,
	input  logic signed [7:0]    move_pri,
	input  logic [NOUT_W-1:0]    cards_out,
	output pss_stat_t            stat,
	output logic                 done,
	output logic [15:0]          tag_out,
	output logic                 got_item,
	output logic                 dropped,
	output logic [6:0]           queue_index
);

	// latched command word
	logic                kind_q;
	logic [TAG_BITS-1:0] tag_q;
	logic [QW-1:0]       pri_q;

	// pool and scheduler state
	logic [PW-1:0]       free_head_q, hw_q, used_q;
	logic [QUEUE_COUNT-1:0] nonempty_q;
	logic [QW-1:0]       top_q;
	logic [7:0]          pos_q, floor_q;

	// sweep walker
	logic signed [SW-1:0] q_q, lo_q;
	logic                 last_q;
	logic [IW-1:0]        node_q;

	// result word
	logic                done_q, got_q, drop_q;
	logic [15:0]         tout_q;
	logic [6:0]          qidx_q;

	// memories
	logic            head_we, link_we, tag_we;
	logic [QW-1:0]   head_wa, head_ra;
	logic [PW-1:0]   head_wd, head_rd, link_wd, link_rd;
	logic [IW-1:0]   link_wa, link_ra, tag_ra;
	logic [TAG_BITS-1:0] tag_rd;

	// queue number of a push
	logic signed [9:0] pri_sum;
	logic [QW-1:0]     pri_new;

	always_comb begin
		pri_sum = 10'(move_pri) + 10'(SQUASH_TBL[cards_out]);
		if (pri_sum < 0) pri_new = '0;
		else if (pri_sum > 10'(QUEUE_COUNT - 1)) pri_new = QW'(QUEUE_COUNT - 1);
		else pri_new = pri_sum[QW-1:0];
	end

	// one sweep step, top drop step after a pop, pool full
	logic signed [SW-1:0] top_s, q_dec, lo_dec, lo_wrap, q_nxt, lo_nxt;
	logic                 wrap, last_nxt;
	logic signed [SW-1:0] q_down;

	always_comb begin
		top_s    = SW'({1'b0, top_q});
		q_dec    = q_q - SW'(1);
		wrap     = q_dec < lo_q;
		lo_dec   = lo_q - SW'(1);
		lo_wrap  = (lo_dec < 0) ? top_s : lo_dec;
		q_nxt    = wrap ? top_s : q_dec;
		lo_nxt   = wrap ? lo_wrap : lo_q;
		last_nxt = last_q | (wrap && lo_wrap == 0);
		stat.sw_empty = wrap & last_q;
		stat.sw_found = !stat.sw_empty & nonempty_q[q_nxt[QW-1:0]];
		q_down       = q_q - SW'(1);
		stat.drop_go = !nonempty_q[q_q[QW-1:0]] && q_q == top_s && top_q != '0;
		stat.full    = (used_q >= PW'(POOL_DEPTH)) || (free_head_q >= NULL_NODE);
	end

	// memory port steering
	logic [PW-1:0] push_link;
	logic [PW-1:0] next_free;
	always_comb begin
		push_link = nonempty_q[pri_q] ? head_rd : NULL_NODE;
		next_free = (free_head_q == hw_q) ? free_head_q + PW'(1) : link_rd;
		head_ra   = kind_q ? q_q[QW-1:0] : pri_q;
		head_we   = cmd.push_wr | cmd.pop_wr;
		head_wa   = kind_q ? q_q[QW-1:0] : pri_q;
		head_wd   = kind_q ? link_rd : PW'(free_head_q[IW-1:0]);
		link_ra   = kind_q ? head_rd[IW-1:0] : free_head_q[IW-1:0];
		link_we   = cmd.push_wr | cmd.pop_wr;
		link_wa   = kind_q ? node_q : free_head_q[IW-1:0];
		link_wd   = kind_q ? free_head_q : push_link;
		tag_ra    = head_rd[IW-1:0];
		tag_we    = cmd.push_wr;
	end

	pss_ram #(.WIDTH(PW), .DEPTH(QUEUE_COUNT)) u_head (
		.clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
		.raddr(head_ra), .rdata(head_rd)
	);

	pss_ram #(.WIDTH(PW), .DEPTH(POOL_DEPTH)) u_link (
		.clk(clk), .we(link_we), .waddr(link_wa), .wdata(link_wd),
		.raddr(link_ra), .rdata(link_rd)
	);

	pss_ram #(.WIDTH(TAG_BITS), .DEPTH(POOL_DEPTH)) u_tag (
		.clk(clk), .we(tag_we), .waddr(free_head_q[IW-1:0]), .wdata(tag_q),
		.raddr(tag_ra), .rdata(tag_rd)
	);

	// command word and walker registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			tag_q  <= tag[TAG_BITS-1:0];
			pri_q  <= pri_new;
			q_q    <= SW'({1'b0, pos_q});
			lo_q   <= SW'({1'b0, floor_q});
			last_q <= 1'b0;
		end
		if (cmd.sweep) begin
			q_q    <= q_nxt;
			lo_q   <= lo_nxt;
			last_q <= last_nxt;
		end
		if (cmd.pop_node) begin
			node_q <= head_rd[IW-1:0];
		end
		if (cmd.drop && stat.drop_go) begin
			q_q <= q_down;
			if (q_down < lo_q) lo_q <= q_down;
		end
	end

	// pool, occupancy and sweep state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			hw_q        <= '0;
			used_q      <= '0;
			nonempty_q  <= '0;
			top_q       <= '0;
			pos_q       <= '0;
			floor_q     <= '0;
		end else begin
			if (cmd.push_wr) begin
				free_head_q <= next_free;
				if (free_head_q == hw_q) hw_q <= hw_q + PW'(1);
				used_q <= used_q + PW'(1);
				nonempty_q[pri_q] <= 1'b1;
				if (pri_q > top_q) top_q <= pri_q;
			end
			if (cmd.sweep && stat.sw_empty) begin
				pos_q   <= '0;
				floor_q <= lo_q[7:0];
			end
			if (cmd.pop_wr) begin
				free_head_q <= PW'(node_q);
				used_q <= used_q - PW'(1);
				if (link_rd == NULL_NODE) nonempty_q[q_q[QW-1:0]] <= 1'b0;
			end
			if (cmd.drop) begin
				if (stat.drop_go) begin
					top_q <= top_q - QW'(1);
				end else begin
					pos_q   <= q_q[7:0];
					floor_q <= lo_q[7:0];
				end
			end
		end
	end

	// result word, one cycle per result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
			got_q  <= 1'b0;
			drop_q <= 1'b0;
			tout_q <= '0;
			qidx_q <= '0;
		end else begin
			done_q <= 1'b0;
			if ((cmd.push_chk && stat.full) || cmd.push_wr) begin
				done_q <= 1'b1;
				got_q  <= 1'b0;
				drop_q <= cmd.push_chk;
				tout_q <= '0;
				qidx_q <= 7'(pri_q);
			end
			if (cmd.sweep && stat.sw_empty) begin
				done_q <= 1'b1;
				got_q  <= 1'b0;
				drop_q <= 1'b0;
				tout_q <= '0;
				qidx_q <= '0;
			end
			if (cmd.pop_wr) begin
				done_q <= 1'b1;
				got_q  <= 1'b1;
				drop_q <= 1'b0;
				tout_q <= 16'(tag_rd);
				qidx_q <= 7'(q_q[QW-1:0]);
			end
		end
	end

	assign done        = done_q;
	assign got_item    = got_q;
	assign dropped     = drop_q;
	assign tag_out     = tout_q;
	assign queue_index = qidx_q;

endmodule

>>> verif/pss_checker.sv
// Checker for the priority stack sweep scheduler: watches accepted command words and
// result words, predicts each result with its own scheduler state and compares.
// Depends on pss_pkg for sizes.
`timescale 1ns / 1ps
module pss_checker import pss_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              kind,
	input  logic [15:0]       tag,
	input  logic signed [7:0] move_pri,
	input  logic [6:0]        cards_out,
	input  logic              done,
	input  logic [15:0]       tag_out,
	input  logic              got_item,
	input  logic              dropped,
	input  logic [6:0]        queue_index,
	output int                err_count,
	output int                pending
);

	typedef struct {
		logic [15:0] tag_out;
		logic        got_item;
		logic        dropped;
		logic [6:0]  queue_index;
	} sched_word_t;

	sched_word_t pending_words[$];

	// scheduler state mirror
	int unsigned stack_head[QUEUE_COUNT];
	int unsigned next_link[POOL_DEPTH];
	logic [15:0] node_tag[POOL_DEPTH];
	int unsigned free_node, nodes_used;
	int top_q, sweep_q, sweep_lo;

	function automatic int unsigned head_of(int q);
		if (q < 0 || q >= QUEUE_COUNT)
			return POOL_DEPTH;
		return stack_head[q];
	endfunction

	function automatic sched_word_t schedule(logic k, logic [15:0] t,
			logic signed [7:0] mp, logic [6:0] n);
		sched_word_t w;
		int pri, q, lo;
		int unsigned node, num;
		bit last_sweep;
		w = '{16'd0, 1'b0, 1'b0, 7'd0};
		if (!k) begin
			num = 32 * n * n + 3200 * n + 5000;
			pri = int'(mp) + int'(num / 10000) - 3;
			if (pri < 0)
				pri = 0;
			else if (pri >= QUEUE_COUNT)
				pri = QUEUE_COUNT - 1;
			w.queue_index = 7'(pri);
			if (nodes_used >= POOL_DEPTH || free_node >= POOL_DEPTH) begin
				w.dropped = 1'b1;
				return w;
			end
			node = free_node;
			free_node = next_link[node];
			nodes_used++;
			if (pri > top_q)
				top_q = pri;
			node_tag[node] = t;
			next_link[node] = stack_head[pri];
			stack_head[pri] = node;
			return w;
		end
		// round-robin sweep with a falling floor
		last_sweep = 0;
		q = sweep_q;
		lo = sweep_lo;
		do begin
			q--;
			if (q < lo) begin
				if (last_sweep) begin
					sweep_q = 0;
					sweep_lo = lo;
					return w;
				end
				q = top_q;
				lo--;
				if (lo < 0)
					lo = top_q;
				if (lo == 0)
					last_sweep = 1;
			end
		end while (head_of(q) == POOL_DEPTH);
		node = stack_head[q];
		stack_head[q] = next_link[node];
		w.tag_out = node_tag[node];
		w.got_item = 1'b1;
		w.queue_index = 7'(q);
		next_link[node] = free_node;
		free_node = node;
		nodes_used--;
		// top mark drops past emptied queues
		while (head_of(q) == POOL_DEPTH && q == top_q && top_q > 0) begin
			top_q--;
			q--;
			if (q < lo)
				lo = q;
		end
		sweep_q = q;
		sweep_lo = lo;
		return w;
	endfunction

	assign pending = pending_words.size();

	always @(posedge clk or negedge arst_n) begin
		sched_word_t w;
		int errs;
		if (!arst_n) begin
			for (int i = 0; i < QUEUE_COUNT; i++)
				stack_head[i] = POOL_DEPTH;
			for (int i = 0; i < POOL_DEPTH; i++) begin
				next_link[i] = i + 1;
				node_tag[i] = '0;
			end
			free_node = 0;
			nodes_used = 0;
			top_q = 0;
			sweep_q = 0;
			sweep_lo = 0;
			pending_words.delete();
			err_count <= 0;
		end else begin
			errs = 0;
			// result word first: a word is never answered in its own accept cycle
			if (done) begin
				if (pending_words.size() == 0) begin
					$error("result word with nothing expected");
					errs++;
				end else begin
					w = pending_words.pop_front();
					if (tag_out !== w.tag_out) begin
						$error("tag_out: expected %0h, got %0h", w.tag_out, tag_out);
						errs++;
					end
					if (got_item !== w.got_item) begin
						$error("got_item: expected %0b, got %0b", w.got_item, got_item);
						errs++;
					end
					if (dropped !== w.dropped) begin
						$error("dropped: expected %0b, got %0b", w.dropped, dropped);
						errs++;
					end
					if (queue_index !== w.queue_index) begin
						$error("queue_index: expected %0d, got %0d",
							w.queue_index, queue_index);
						errs++;
					end
				end
			end
			if (errs != 0)
				err_count <= err_count + errs;
			if (start && !busy)
				pending_words.push_back(schedule(kind, tag, move_pri, cards_out));
		end
	end

endmodule

>>> verif/tb_top.sv
// Testbench top for the priority stack sweep scheduler: clock, reset, command stimulus
// and verdict. Depends on pss_checker and the scheduler core.
`timescale 1ns / 1ps
module tb_top;

	logic              clk, arst_n, start, busy, kind, done, got_item, dropped;
	logic [15:0]       tag, tag_out;
	logic signed [7:0] move_pri;
	logic [6:0]        cards_out, queue_index;
	int                err_count, pending;
	int                idle_pct;
	bit                drain_timeout;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	priority_stack_sweep_scheduler_core dut (.*);
	pss_checker chk (.*);

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	// drive one command word and hold it until accepted
	task automatic send_word(logic k, logic [15:0] t, logic signed [7:0] mp,
			logic [6:0] n);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		kind <= k;
		tag <= t;
		move_pri <= mp;
		cards_out <= n;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic push_rand();
		send_word(CMD_PUSH, 16'($urandom), 8'($urandom), 7'($urandom_range(104)));
	endtask

	task automatic run_random(int count);
		int r;
		for (int i = 0; i < count; i++) begin
			r = $urandom_range(99);
			if (r < 50)
				push_rand();
			else if (r < 95)
				send_word(CMD_POP, 16'($urandom), 8'($urandom), 7'($urandom));
			else
				send_word(CMD_PUSH, 16'($urandom), 8'($urandom), 7'($urandom));
		end
	endtask

	initial begin
		#3000000;
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		kind = CMD_PUSH;
		tag = '0;
		move_pri = '0;
		cards_out = '0;
		idle_pct = 0;
		drain_timeout = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty pop, extremes, clamps, out-of-range cards_out
		send_word(CMD_POP, 16'hFFFF, 8'sd0, 7'd0);
		send_word(CMD_PUSH, 16'hFFFF, -8'sd128, 7'd0);
		send_word(CMD_PUSH, 16'h0000, 8'sd127, 7'd104);
		send_word(CMD_PUSH, 16'hA5A5, 8'sd127, 7'd127);
		send_word(CMD_PUSH, 16'h5A5A, 8'sd3, 7'd0);
		send_word(CMD_PUSH, 16'h1234, 8'sd40, 7'd50);
		send_word(CMD_PUSH, 16'h4321, 8'sd40, 7'd50);
		repeat (7)
			send_word(CMD_POP, 16'h0, 8'sd0, 7'd0);
		send_word(CMD_PUSH, 16'h0F0F, -8'sd1, 7'd10);
		send_word(CMD_POP, 16'h0, 8'sd0, 7'd0);

		idle_pct = 23;
		run_random(211);
		idle_pct = 57;
		run_random(211);
		idle_pct = 0;
		run_random(211);
		start <= 1'b0;

		fork
			begin
				while (pending != 0)
					@(posedge clk);
				repeat (300) @(posedge clk);
			end
			begin
				repeat (200000) @(posedge clk);
				drain_timeout = 1'b1;
			end
		join_any
		disable fork;
		if (err_count == 0 && !drain_timeout)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

>>> priority_stack_sweep_scheduler_core.f
sv/pss_pkg.sv
sv/pss_ram.sv
sv/pss_ctrl.sv
sv/pss_dpath.sv
sv/priority_stack_sweep_scheduler_core.sv
verif/pss_checker.sv
verif/tb_top.sv
